// ===== rtl/csti_pkg.sv =====
`timescale 1ns / 1ps
package csti_pkg;

    localparam int unsigned NUM_POINTS_DEF    = 57;
    localparam int unsigned NUM_MATERIALS_DEF = 8;
    localparam int unsigned MAX_POINTS        = 128;
    localparam int unsigned MAX_MATERIALS     = 16;
    localparam int unsigned E_W   = 21;
    localparam int unsigned MAT_W = 3;
    localparam int unsigned OUT_W = 22;
    localparam int unsigned MB_W  = 12;
    localparam int unsigned SEG_W = 7;
    // dx*dc*1000 magnitude: 21 + 12 + 10 bits
    localparam int unsigned NUM_W = 43;
    localparam int unsigned Q_W   = 22;

    typedef struct packed {
        logic start;   // begin an item
        logic load_seg;
        logic div_go;  // start the dividers
        logic take;    // output taken
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_sts;

    function automatic logic [E_W-1:0] f_e_kev(input logic [SEG_W-1:0] i);
        logic [E_W-1:0] v;
        v = E_W'(0);
        case (i)
            7'd0: v = 21'd500;      7'd1: v = 21'd1000;     7'd2: v = 21'd1500;
            7'd3: v = 21'd2000;     7'd4: v = 21'd2500;     7'd5: v = 21'd3000;
            7'd6: v = 21'd3500;     7'd7: v = 21'd4000;     7'd8: v = 21'd4500;
            7'd9: v = 21'd5000;     7'd10: v = 21'd5500;    7'd11: v = 21'd6000;
            7'd12: v = 21'd6500;    7'd13: v = 21'd7000;    7'd14: v = 21'd7500;
            7'd15: v = 21'd8000;    7'd16: v = 21'd9000;    7'd17: v = 21'd10000;
            7'd18: v = 21'd11000;   7'd19: v = 21'd12000;   7'd20: v = 21'd13000;
            7'd21: v = 21'd14000;   7'd22: v = 21'd15000;   7'd23: v = 21'd17500;
            7'd24: v = 21'd20000;   7'd25: v = 21'd22500;   7'd26: v = 21'd25000;
            7'd27: v = 21'd30000;   7'd28: v = 21'd35000;   7'd29: v = 21'd40000;
            7'd30: v = 21'd45000;   7'd31: v = 21'd50000;   7'd32: v = 21'd51000;
            7'd33: v = 21'd55000;   7'd34: v = 21'd60000;   7'd35: v = 21'd70000;
            7'd36: v = 21'd80000;   7'd37: v = 21'd90000;   7'd38: v = 21'd100000;
            7'd39: v = 21'd110000;  7'd40: v = 21'd120000;  7'd41: v = 21'd140000;
            7'd42: v = 21'd160000;  7'd43: v = 21'd180000;  7'd44: v = 21'd200000;
            7'd45: v = 21'd225000;  7'd46: v = 21'd250000;  7'd47: v = 21'd275000;
            7'd48: v = 21'd300000;  7'd49: v = 21'd325000;  7'd50: v = 21'd350000;
            7'd51: v = 21'd375000;  7'd52: v = 21'd400000;  7'd53: v = 21'd500000;
            7'd54: v = 21'd700000;  7'd55: v = 21'd1000000; 7'd56: v = 21'd1500000;
            default: v = E_W'(0);
        endcase
        return v;
    endfunction

    typedef logic [MB_W-1:0] t_row [0:56];

    localparam t_row EL0 = '{0,0,0,0,0,321,335,349,363,377,386,395,404,413,423,
        434,456,479,509,539,569,598,628,685,743,783,822,878,915,938,
        813,688,678,641,594,515,448,392,345,305,272,214,167,138,117,
        98,85,77,72,68,67,66,67,77,90,102,108};
    localparam t_row EL1 = '{0,0,0,0,0,91,164,237,311,384,428,473,518,562,607,
        623,654,686,692,699,701,700,700,707,714,737,761,832,905,976,
        993,1010,1007,994,979,921,854,786,720,658,601,490,382,320,274,
        231,202,181,167,159,153,151,151,170,198,220,232};
    localparam t_row EL2 = '{0,0,0,0,0,1,15,30,45,59,109,159,209,259,309,
        364,474,584,668,753,819,867,915,964,1013,1030,1047,1063,1075,1098,
        1121,1143,1153,1192,1240,1293,1306,1289,1250,1198,1137,984,777,669,582,
        499,438,393,361,340,325,317,314,346,389,425,444};
    localparam t_row EL3 = '{0,0,0,0,0,0,17,25,33,77,121,165,208,252,310,
        426,541,634,726,800,855,910,971,1033,1058,1083,1113,1132,1156,1161,
        1165,1175,1216,1268,1337,1368,1368,1343,1300,1245,1092,869,752,657,565,
        496,446,410,384,368,358,353,385,429,468,488,0};
    localparam t_row EL4 = '{0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,
        4,11,19,72,126,207,316,425,704,982,1124,1266,1401,1506,1586,
        1593,1600,1608,1639,1679,1773,1884,2001,2109,2198,2261,2255,1984,1831,1679,
        1506,1359,1240,1146,1070,1022,985,963,997,1053,1119,1186};
    localparam t_row EL5 = '{0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,
        3,10,17,67,118,197,305,412,694,975,1121,1267,1404,1511,1591,
        1600,1610,1618,1649,1689,1782,1893,2010,2120,2211,2276,2275,2006,1852,1700,
        1526,1378,1258,1163,1090,1037,1000,977,1011,1067,1134,1171};
    localparam t_row EL6 = '{0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,
        2,6,10,51,91,161,261,361,654,947,1108,1269,1416,1530,1614,
        1632,1651,1659,1691,1731,1821,1931,2051,2166,2265,2340,2365,2096,1944,1790,
        1613,1460,1335,1235,1159,1103,1063,1038,1072,1129,1198,1236};
    localparam t_row EL7 = '{0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,
        1,4,7,40,74,138,231,325,625,925,1097,1270,1426,1545,1633,
        1659,1684,1692,1725,1765,1853,1962,2083,2203,2309,2392,2423,2170,2020,1865,
        1685,1528,1399,1296,1216,1158,1116,1090,1124,1181,1251,1291};
    localparam t_row IN0 = '{0,0,0,0,0,0,0,0,0,13,78,131,175,212,244,
        271,314,346,370,389,403,413,421,432,434,432,427,412,394,376,
        359,344,288,281,272,257,245,235,228,223,220,223,213,212,212,
        212,213,214,216,217,219,221,223,229,246,261,261};
    localparam t_row IN1 = '{0,0,0,0,123,280,391,474,537,587,626,658,684,705,722,
        736,757,771,780,785,787,787,786,777,764,749,732,699,667,638,
        611,587,530,518,503,478,456,437,422,410,402,397,394,393,392,
        393,395,397,399,402,405,408,411,415,438,457,460};
    localparam t_row IN2 = '{0,0,0,0,0,0,0,17,174,301,404,490,562,623,676,
        721,795,852,896,931,959,981,999,1028,1044,1050,1050,1040,1021,999,
        976,952,920,899,873,834,790,753,719,698,685,672,677,674,673,
        674,675,678,681,685,689,693,697,679,710,735,744};
    localparam t_row IN3 = '{0,0,0,0,0,0,0,63,225,354,460,548,622,685,739,
        786,862,920,966,1003,1032,1055,1073,1104,1121,1128,1128,1118,1100,1077,
        1053,1029,986,966,942,902,859,822,788,765,749,732,736,733,732,
        732,734,737,740,744,748,752,756,736,768,794,805};
    localparam t_row IN4 = '{0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,
        12,286,505,685,833,958,1065,1156,1334,1462,1557,1628,1723,1779,1810,
        1825,1831,1824,1823,1821,1807,1784,1761,1736,1705,1676,1629,1604,1591,1578,
        1574,1568,1564,1560,1555,1551,1546,1541,1549,1599,1641,1666};
    localparam t_row IN5 = '{0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,
        0,265,489,672,823,951,1059,1152,1334,1465,1562,1635,1733,1790,1823,
        1840,1846,1840,1839,1838,1825,1804,1782,1759,1728,1700,1653,1626,1612,1599,
        1594,1588,1583,1578,1573,1568,1562,1557,1568,1618,1659,1686};
    localparam t_row IN6 = '{0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,
        0,149,392,591,757,896,1015,1117,1317,1462,1570,1652,1763,1830,1870,
        1893,1904,1967,1953,1935,1909,1878,1842,1806,1768,1734,1682,1664,1656,1649,
        1647,1647,1647,1648,1649,1650,1651,1653,1644,1695,1738,1766};
    localparam t_row IN7 = '{0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,
        0,90,346,556,731,878,1004,1112,1325,1479,1594,1682,1803,1877,1922,
        1948,1962,2074,2048,2015,1979,1939,1892,1845,1801,1762,1706,1695,1691,1690,
        1691,1695,1699,1705,1712,1718,1725,1733,1711,1763,1807,1836};

    // Look up one millibarn value; inel selects the inelastic table
    function automatic logic [MB_W-1:0] f_mb(input logic inel, input logic [MAT_W-1:0] m,
                                            input logic [SEG_W-1:0] i);
        logic [MB_W-1:0] v;
        logic [5:0]      k;
        k = i[5:0];
        v = MB_W'(0);
        if (i < SEG_W'(57)) begin
            case ({inel, m})
                4'd0: v = EL0[k];  4'd1: v = EL1[k];  4'd2: v = EL2[k];  4'd3: v = EL3[k];
                4'd4: v = EL4[k];  4'd5: v = EL5[k];  4'd6: v = EL6[k];  4'd7: v = EL7[k];
                4'd8: v = IN0[k];  4'd9: v = IN1[k];  4'd10: v = IN2[k]; 4'd11: v = IN3[k];
                4'd12: v = IN4[k]; 4'd13: v = IN5[k]; 4'd14: v = IN6[k]; 4'd15: v = IN7[k];
                default: v = MB_W'(0);
            endcase
        end
        return v;
    endfunction

endpackage

// ===== rtl/csti_if.sv =====
`timescale 1ns / 1ps
interface csti_in_if;
    logic                          valid;
    logic                          ready;
    logic [csti_pkg::E_W-1:0]      energy_kev;
    logic [csti_pkg::MAT_W-1:0]    material;
    modport source (output valid, energy_kev, material, input ready);
    modport sink   (input valid, energy_kev, material, output ready);
endinterface

interface csti_out_if;
    logic                          valid;
    logic                          ready;
    logic [csti_pkg::OUT_W-1:0]    elastic_ub;
    logic [csti_pkg::OUT_W-1:0]    inelastic_ub;
    logic                          out_of_range;
    modport source (output valid, elastic_ub, inelastic_ub, out_of_range, input ready);
    modport sink   (input valid, elastic_ub, inelastic_ub, out_of_range, output ready);
endinterface

// ===== rtl/cross_section_table_interpolator.sv =====
`timescale 1ns / 1ps
// The breakpoint scan takes one segment a cycle; the restoring divider one bit a cycle.
// One request at a time; the next is taken the cycle after the result is accepted.
// Reset: synchronous, active low; clears the controller and divider, no result pending.
module cross_section_table_interpolator #(
    parameter int unsigned NUM_POINTS    = csti_pkg::NUM_POINTS_DEF,
    parameter int unsigned NUM_MATERIALS = csti_pkg::NUM_MATERIALS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    csti_in_if.sink    i_req,
    csti_out_if.source o_res
);
    import csti_pkg::*;

    t_cmd cmd;
    t_sts sts;

    csti_ctrl #(.NUM_POINTS(NUM_POINTS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    csti_dp #(.NUM_POINTS(NUM_POINTS), .NUM_MATERIALS(NUM_MATERIALS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_energy_kev   (i_req.energy_kev),
        .i_material     (i_req.material),
        .o_elastic_ub   (o_res.elastic_ub),
        .o_inelastic_ub (o_res.inelastic_ub),
        .o_out_of_range (o_res.out_of_range)
    );
endmodule

// ===== rtl/csti_ctrl.sv =====
`timescale 1ns / 1ps
module csti_ctrl #(
    parameter int unsigned NUM_POINTS = csti_pkg::NUM_POINTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  csti_pkg::t_sts    i_sts,
    output csti_pkg::t_cmd    o_cmd
);
    import csti_pkg::*;

    localparam int unsigned SCAN_W = $clog2(NUM_POINTS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_LOAD = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [SCAN_W-1:0]   r_cnt, n_cnt;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // Sequence: scan breakpoints, load segment, divide, present
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_cnt       = '0;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt == SCAN_W'(NUM_POINTS - 2)) n_state = S_LOAD;
                else n_cnt = r_cnt + SCAN_W'(1);
            end
            S_LOAD: begin
                o_cmd.load_seg = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        o_cmd.div_go = (r_state == S_LOAD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_noacc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("accept while result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid) else $error("result dropped");
endmodule

// ===== rtl/csti_dp.sv =====
`timescale 1ns / 1ps
module csti_dp #(
    parameter int unsigned NUM_POINTS    = csti_pkg::NUM_POINTS_DEF,
    parameter int unsigned NUM_MATERIALS = csti_pkg::NUM_MATERIALS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  csti_pkg::t_cmd                i_cmd,
    output csti_pkg::t_sts                o_sts,
    input  logic [csti_pkg::E_W-1:0]      i_energy_kev,
    input  logic [csti_pkg::MAT_W-1:0]    i_material,
    output logic [csti_pkg::OUT_W-1:0]    o_elastic_ub,
    output logic [csti_pkg::OUT_W-1:0]    o_inelastic_ub,
    output logic                          o_out_of_range
);
    import csti_pkg::*;

    localparam int unsigned SCAN_W = $clog2(NUM_POINTS);
    localparam int unsigned DIV_CNT_W = $clog2(NUM_W + 1);
    localparam int unsigned R_W = E_W + 1;

    logic [E_W-1:0]     r_e;
    logic [MAT_W-1:0]   r_mat;
    logic               r_oor;
    logic [SCAN_W-1:0]  r_scan, r_seg;
    logic [E_W-1:0]     r_den;
    logic [NUM_W-1:0]   r_num_el, r_num_in;
    logic               r_neg_el, r_neg_in;
    logic [MB_W-1:0]    r_clo_el, r_clo_in;
    logic [R_W-1:0]     r_rem_el, r_rem_in;
    logic [DIV_CNT_W-1:0] r_dcnt;
    logic               r_busy;
    logic [OUT_W-1:0]   r_res_el, r_res_in;

    logic [E_W-1:0]     e_first, e_last, e_lo, e_hi, e_i, e_i1, dx;
    logic [SEG_W-1:0]   seg7;
    logic [MB_W-1:0]    el_lo, el_hi, in_lo, in_hi;

    assign e_first = f_e_kev(SEG_W'(0));
    assign e_last  = f_e_kev(SEG_W'(NUM_POINTS - 1));
    assign e_i     = f_e_kev(SEG_W'(r_scan));
    assign e_i1    = f_e_kev(SEG_W'(r_scan) + SEG_W'(1));
    assign seg7    = SEG_W'(r_seg);
    assign e_lo    = f_e_kev(seg7);
    assign e_hi    = f_e_kev(seg7 + SEG_W'(1));
    assign dx      = r_e - e_lo;
    assign el_lo   = f_mb(1'b0, r_mat, seg7);
    assign el_hi   = f_mb(1'b0, r_mat, seg7 + SEG_W'(1));
    assign in_lo   = f_mb(1'b1, r_mat, seg7);
    assign in_hi   = f_mb(1'b1, r_mat, seg7 + SEG_W'(1));

    // Magnitude of dx*|dc|*1000
    function automatic logic [NUM_W-1:0] f_prod(input logic [E_W-1:0] d,
                                               input logic [MB_W-1:0] m);
        logic [NUM_W-1:0] p;
        p = NUM_W'(d) * NUM_W'(m);
        return NUM_W'(p * NUM_W'(1000));
    endfunction

    logic [MB_W-1:0] del_el, del_in;
    assign del_el = (el_hi >= el_lo) ? el_hi - el_lo : el_lo - el_hi;
    assign del_in = (in_hi >= in_lo) ? in_hi - in_lo : in_lo - in_hi;

    // Restoring divide step, one quotient bit per cycle for both results
    logic [R_W-1:0] t_el, t_in;
    assign t_el = {r_rem_el[R_W-2:0], r_num_el[NUM_W-1]};
    assign t_in = {r_rem_in[R_W-2:0], r_num_in[NUM_W-1]};

    always_ff @(posedge i_clk) begin
        // capture request with clamping
        if (i_cmd.start) begin
            r_mat  <= (i_material >= MAT_W'(NUM_MATERIALS - 1)) ?
                      MAT_W'(NUM_MATERIALS - 1) : i_material;
            r_scan <= '0;
            r_seg  <= '0;
            if (i_energy_kev < e_first) begin
                r_e <= e_first; r_oor <= 1'b1;
            end else if (i_energy_kev > e_last) begin
                r_e <= e_last;  r_oor <= 1'b1;
            end else begin
                r_e <= i_energy_kev; r_oor <= 1'b0;
            end
        end else if (!i_cmd.load_seg && !r_busy && r_scan != SCAN_W'(NUM_POINTS - 1)) begin
            // scan one segment per cycle, keep the last match
            if (e_i <= r_e && r_e <= e_i1) r_seg <= r_scan;
            r_scan <= r_scan + SCAN_W'(1);
        end
        if (i_cmd.load_seg) begin
            r_den    <= e_hi - e_lo;
            r_num_el <= f_prod(dx, del_el);
            r_num_in <= f_prod(dx, del_in);
            r_neg_el <= el_hi < el_lo;
            r_neg_in <= in_hi < in_lo;
            r_clo_el <= el_lo;
            r_clo_in <= in_lo;
            r_rem_el <= '0;
            r_rem_in <= '0;
        end else if (r_busy) begin
            if (t_el >= R_W'(r_den)) begin
                r_rem_el <= t_el - R_W'(r_den);
                r_num_el <= {r_num_el[NUM_W-2:0], 1'b1};
            end else begin
                r_rem_el <= t_el;
                r_num_el <= {r_num_el[NUM_W-2:0], 1'b0};
            end
            if (t_in >= R_W'(r_den)) begin
                r_rem_in <= t_in - R_W'(r_den);
                r_num_in <= {r_num_in[NUM_W-2:0], 1'b1};
            end else begin
                r_rem_in <= t_in;
                r_num_in <= {r_num_in[NUM_W-2:0], 1'b0};
            end
        end
    end

    // Divider iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_dcnt <= '0;
        end else if (i_cmd.div_go) begin
            r_busy <= 1'b1;
            r_dcnt <= '0;
        end else if (r_busy) begin
            if (r_dcnt == DIV_CNT_W'(NUM_W - 1)) r_busy <= 1'b0;
            r_dcnt <= r_dcnt + DIV_CNT_W'(1);
        end
    end

    // Combine with base value; zero-width segment gives slope 0
    logic [OUT_W-1:0] q_el, q_in, b_el, b_in;
    assign q_el = (r_den == '0) ? '0 : r_num_el[OUT_W-1:0];
    assign q_in = (r_den == '0) ? '0 : r_num_in[OUT_W-1:0];
    assign b_el = OUT_W'(r_clo_el * 22'd1000);
    assign b_in = OUT_W'(r_clo_in * 22'd1000);

    always_ff @(posedge i_clk) begin
        if (!r_busy && !i_cmd.div_go && !i_cmd.load_seg) begin
            r_res_el <= r_neg_el ? b_el - q_el : b_el + q_el;
            r_res_in <= r_neg_in ? b_in - q_in : b_in + q_in;
        end
    end

    assign o_sts.div_done = !r_busy && !i_cmd.div_go;
    assign o_elastic_ub   = r_res_el;
    assign o_inelastic_ub = r_res_in;
    assign o_out_of_range = r_oor;

    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_seg |-> (r_seg <= SCAN_W'(NUM_POINTS - 2)))
        else $error("segment out of range");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_go |=> r_busy) else $error("divider not started");
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.start) |-> (r_e >= e_first && r_e <= e_last)) else $error("clamp");
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import csti_pkg::*;

    typedef struct packed {
        logic [E_W-1:0]   energy_kev;
        logic [MAT_W-1:0] material;
    } t_req;

    typedef struct packed {
        logic [OUT_W-1:0] elastic_ub;
        logic [OUT_W-1:0] inelastic_ub;
        logic             out_of_range;
    } t_xs;

    localparam int unsigned LAST_PT = NUM_POINTS_DEF - 1;

    logic i_clk;
    logic i_rst_n;

    csti_in_if  req_if ();
    csti_out_if res_if ();

    cross_section_table_interpolator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source)
    );

    t_req   pending_reqs[$];
    t_xs    expected_xs[$];
    int     num_errors = 0;
    int     num_checked = 0;
    int     num_oor = 0;
    bit     quiet_phase = 0;
    int     src_gap = 0;
    int     snk_stall = 0;

    // Interpolate one row of the millibarn table, result in microbarns
    function automatic logic [OUT_W-1:0] lerp_row(input logic inel, input int mat,
                                                  input int seg, input longint e);
        longint clo, chi, dx, den, q, r;
        clo = longint'(f_mb(inel, MAT_W'(mat), SEG_W'(seg)));
        chi = longint'(f_mb(inel, MAT_W'(mat), SEG_W'(seg + 1)));
        dx  = e - longint'(f_e_kev(SEG_W'(seg)));
        den = longint'(f_e_kev(SEG_W'(seg + 1))) - longint'(f_e_kev(SEG_W'(seg)));
        q   = 0;
        if (den > 0)
            q = (dx * (chi - clo) * 1000) / den;
        r = clo * 1000 + q;
        if (r < 0)
            r = 0;
        return OUT_W'(r);
    endfunction

    function automatic t_xs predict_xs(input t_req rq);
        t_xs    xs;
        longint e;
        int     mat;
        int     seg;
        e   = longint'(rq.energy_kev);
        mat = int'(rq.material);
        seg = 0;
        xs.out_of_range = 1'b0;
        if (mat >= NUM_MATERIALS_DEF)
            mat = NUM_MATERIALS_DEF - 1;
        if (e < longint'(f_e_kev(SEG_W'(0)))) begin
            e = longint'(f_e_kev(SEG_W'(0)));
            xs.out_of_range = 1'b1;
        end else if (e > longint'(f_e_kev(SEG_W'(LAST_PT)))) begin
            e = longint'(f_e_kev(SEG_W'(LAST_PT)));
            xs.out_of_range = 1'b1;
        end
        for (int i = 0; i < LAST_PT; i++)
            if (longint'(f_e_kev(SEG_W'(i))) <= e && e <= longint'(f_e_kev(SEG_W'(i + 1))))
                seg = i;
        xs.elastic_ub   = lerp_row(1'b0, mat, seg, e);
        xs.inelastic_ub = lerp_row(1'b1, mat, seg, e);
        return xs;
    endfunction

    function automatic void add_req(input int unsigned e, input int unsigned m);
        t_req rq;
        rq.energy_kev = E_W'(e);
        rq.material   = MAT_W'(m);
        pending_reqs.push_back(rq);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Fill the request queue: directed corners, then random energies
    initial begin
        int unsigned pt;
        // Below table, zero, all-ones, above table
        add_req(0, 0);
        add_req(499, 7);
        add_req(2097151, 7);
        add_req(1500001, 3);
        add_req(1500000, 3);  // material 3 elastic zero at the last breakpoint
        add_req(500, 1);
        add_req(1499999, 3);
        add_req(50500, 5);
        add_req(1000000, 6);
        add_req(1250000, 2);
        add_req(1048576, 4);
        add_req(700001, 0);
        for (int m = 0; m < 8; m++)
            add_req(400000 + m * 12345, m);
        for (int n = 0; n < 1800; n++) begin
            pt = $urandom_range(LAST_PT - 1, 0);
            case ($urandom_range(9, 0))
                0: add_req($urandom_range(2097151, 0), $urandom_range(7, 0));
                1: add_req(32'(f_e_kev(SEG_W'(pt))), $urandom_range(7, 0));
                2: add_req($urandom_range(499, 0), $urandom_range(7, 0));
                3: add_req($urandom_range(2097151, 1500001), $urandom_range(7, 0));
                default: add_req($urandom_range(32'(f_e_kev(SEG_W'(pt + 1))),
                                                32'(f_e_kev(SEG_W'(pt)))),
                                 $urandom_range(7, 0));
            endcase
        end
    end

    // Hold reset low at the start, then release it
    initial begin
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Drive requests from the queue with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid      <= 1'b0;
            req_if.energy_kev <= '0;
            req_if.material   <= '0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_xs.push_back(predict_xs({req_if.energy_kev, req_if.material}));
                void'(pending_reqs.pop_front());
            end
            if (!req_if.valid || req_if.ready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    req_if.valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    t_req nx;
                    nx = pending_reqs[0];
                    req_if.valid      <= 1'b1;
                    req_if.energy_kev <= nx.energy_kev;
                    req_if.material   <= nx.material;
                    if (!quiet_phase && $urandom_range(7, 0) == 0)
                        src_gap <= $urandom_range(15, 1);
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
            quiet_phase <= pending_reqs.size() < 200;
        end
    end

    // Accept and check results, stalling at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_xs.size() == 0) begin
                    $error("result with no request outstanding");
                    num_errors++;
                end else begin
                    t_xs xp;
                    xp = expected_xs.pop_front();
                    num_checked++;
                    if (xp.out_of_range)
                        num_oor++;
                    if (res_if.elastic_ub !== xp.elastic_ub) begin
                        $error("elastic_ub expected %0d got %0d", xp.elastic_ub,
                               res_if.elastic_ub);
                        num_errors++;
                    end
                    if (res_if.inelastic_ub !== xp.inelastic_ub) begin
                        $error("inelastic_ub expected %0d got %0d", xp.inelastic_ub,
                               res_if.inelastic_ub);
                        num_errors++;
                    end
                    if (res_if.out_of_range !== xp.out_of_range) begin
                        $error("out_of_range expected %0d got %0d", xp.out_of_range,
                               res_if.out_of_range);
                        num_errors++;
                    end
                end
            end
            if (snk_stall > 0) begin
                snk_stall <= snk_stall - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                if (!quiet_phase && $urandom_range(7, 0) == 0)
                    snk_stall <= $urandom_range(15, 1);
            end
        end
    end

    // Wait for the queues to drain, then report
    initial begin
        wait (i_rst_n === 1'b1);
        wait (pending_reqs.size() == 0 && expected_xs.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("checked %0d cross-section lookups, %0d of them clamped to the table ends",
                 num_checked, num_oor);
        if (num_errors == 0 && expected_xs.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Bound the run
    initial begin
        #12000000;
        $display("tb failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/csti_pkg.sv
rtl/csti_if.sv
rtl/csti_ctrl.sv
rtl/csti_dp.sv
rtl/cross_section_table_interpolator.sv
bench/tb.sv
